>>> design/clfs_pkg.sv
package clfs_pkg;

    localparam int MAX_ENTRIES_DEF   = 256;
    localparam int METHOD_BYTES_DEF  = 8;
    localparam int NAME_BYTES_DEF    = 64;
    localparam int COMMAND_BYTES_DEF = 1024;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_HASH    = 8'd35;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_UPPER_C = 8'd67;
    localparam logic [7:0] CH_UPPER_H = 8'd72;

    typedef logic [2:0] t_class;
    localparam t_class CLS_OTHER = 3'd0;
    localparam t_class CLS_CH    = 3'd1;
    localparam t_class CLS_HASH  = 3'd2;
    localparam t_class CLS_EOL   = 3'd3;
    localparam t_class CLS_NUL   = 3'd4;
    localparam t_class CLS_COLON = 3'd5;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_METHOD  = 2'd0;
    localparam t_phase PH_NAME    = 2'd1;
    localparam t_phase PH_COMMAND = 2'd2;
    localparam t_phase PH_COMMENT = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_METHOD  = 2'd0;
    localparam t_kind KIND_NAME    = 2'd1;
    localparam t_kind KIND_COMMAND = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
    } t_text;

    typedef struct packed {
        t_class     cls;
        logic [7:0] text_byte;
    } t_item;

    typedef struct packed {
        logic       write_valid;
        t_kind      field_kind;
        logic [7:0] entry_index;
        logic [9:0] char_pos;
        logic [7:0] char_value;
        logic       entry_closed;
        logic       finished;
        logic [8:0] entry_count;
    } t_result;

endpackage

>>> design/clfs_stream_if.sv
interface clfs_stream_if #(
    parameter type t_payload = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/command_file_line_splitter.sv
// Channel    Direction  Payload        Handshake
// i_text     in         t_text         valid / ready, beat on both high
// o_result   out        t_result       valid / ready, beat on both high
//
// One beat of text is taken every cycle unless a stalled result side has filled the pipeline.
// A result passes through a classifier register, a two-entry queue and the parser's output register.
// Reset is synchronous and active low; the parser starts in the method field with no entries.
// A stalled result holds the parser, and the queue lets the input side run on meanwhile.
module command_file_line_splitter #(
    parameter int MAX_ENTRIES   = clfs_pkg::MAX_ENTRIES_DEF,
    parameter int METHOD_BYTES  = clfs_pkg::METHOD_BYTES_DEF,
    parameter int NAME_BYTES    = clfs_pkg::NAME_BYTES_DEF,
    parameter int COMMAND_BYTES = clfs_pkg::COMMAND_BYTES_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    clfs_stream_if.sink   i_text,
    clfs_stream_if.source o_result
);

    clfs_stream_if #(.t_payload(clfs_pkg::t_item)) w_front ();
    clfs_stream_if #(.t_payload(clfs_pkg::t_item)) w_queue ();

    clfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .o_item  (w_front)
    );

    clfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_front),
        .o_item  (w_queue)
    );

    clfs_back #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .METHOD_BYTES  (METHOD_BYTES),
        .NAME_BYTES    (NAME_BYTES),
        .COMMAND_BYTES (COMMAND_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_queue),
        .o_result (o_result)
    );

endmodule

>>> design/clfs_front.sv
module clfs_front (
    input logic           i_clk,
    input logic           i_rst_n,
    clfs_stream_if.sink   i_text,
    clfs_stream_if.source o_item
);

    logic                r_valid;
    clfs_pkg::t_item     r_item;
    clfs_pkg::t_class    w_cls;
    logic [7:0]          w_byte;
    logic                w_take;

    assign w_byte = i_text.payload.text_byte;

    always_comb begin
        case (w_byte)
            clfs_pkg::CH_UPPER_C, clfs_pkg::CH_UPPER_H: w_cls = clfs_pkg::CLS_CH;
            clfs_pkg::CH_HASH:                          w_cls = clfs_pkg::CLS_HASH;
            clfs_pkg::CH_CR, clfs_pkg::CH_LF:           w_cls = clfs_pkg::CLS_EOL;
            clfs_pkg::CH_NUL:                           w_cls = clfs_pkg::CLS_NUL;
            clfs_pkg::CH_COLON:                         w_cls = clfs_pkg::CLS_COLON;
            default:                                    w_cls = clfs_pkg::CLS_OTHER;
        endcase
    end

    assign i_text.ready  = !r_valid || o_item.ready;
    assign w_take        = i_text.valid && i_text.ready;
    assign o_item.valid  = r_valid;
    assign o_item.payload = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.cls       <= w_cls;
            r_item.text_byte <= w_byte;
        end
    end

endmodule

>>> design/clfs_queue.sv
module clfs_queue (
    input logic           i_clk,
    input logic           i_rst_n,
    clfs_stream_if.sink   i_item,
    clfs_stream_if.source o_item
);

    localparam int DEPTH = clfs_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    clfs_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign i_item.ready   = (r_count != NW'(DEPTH));
    assign o_item.valid   = (r_count != '0);
    assign o_item.payload = r_mem[r_rd_ptr];
    assign w_push         = i_item.valid && i_item.ready;
    assign w_pop          = o_item.valid && o_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item.payload;
        end
    end

endmodule

>>> design/clfs_back.sv
module clfs_back #(
    parameter int MAX_ENTRIES   = clfs_pkg::MAX_ENTRIES_DEF,
    parameter int METHOD_BYTES  = clfs_pkg::METHOD_BYTES_DEF,
    parameter int NAME_BYTES    = clfs_pkg::NAME_BYTES_DEF,
    parameter int COMMAND_BYTES = clfs_pkg::COMMAND_BYTES_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    clfs_stream_if.sink   i_item,
    clfs_stream_if.source o_result
);

    localparam int MAX_MN    = (METHOD_BYTES > NAME_BYTES) ? METHOD_BYTES : NAME_BYTES;
    localparam int MAX_FIELD = (MAX_MN > COMMAND_BYTES) ? MAX_MN : COMMAND_BYTES;
    localparam int PW        = $clog2(MAX_FIELD + 1);
    localparam int CW        = $clog2(MAX_ENTRIES + 1);

    localparam logic [PW-1:0] M_SIZE = PW'(METHOD_BYTES);
    localparam logic [PW-1:0] N_SIZE = PW'(NAME_BYTES);
    localparam logic [PW-1:0] C_SIZE = PW'(COMMAND_BYTES);
    localparam logic [PW-1:0] M_LAST = PW'(METHOD_BYTES - 1);
    localparam logic [PW-1:0] N_LAST = PW'(NAME_BYTES - 1);
    localparam logic [PW-1:0] C_LAST = PW'(COMMAND_BYTES - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_ENTRIES);

    clfs_pkg::t_phase  r_phase, n_phase;
    logic [PW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_count, n_count;
    logic              r_swallow, n_swallow;

    logic              r_out_valid;
    clfs_pkg::t_result r_out;

    clfs_pkg::t_class  w_cls;
    logic [7:0]        w_byte;
    logic [PW-1:0]     w_size, w_last;
    logic              w_lt_last, w_at_last, w_lt_size;
    logic [CW-1:0]     w_cnt_inc;
    logic              w_wv, w_closed, w_fin, w_has, w_pop;
    clfs_pkg::t_kind   w_kind;
    logic [7:0]        w_val;
    clfs_pkg::t_result w_res;

    assign w_cls  = i_item.payload.cls;
    assign w_byte = i_item.payload.text_byte;

    always_comb begin
        case (r_phase)
            clfs_pkg::PH_NAME: begin
                w_size = N_SIZE;
                w_last = N_LAST;
            end
            clfs_pkg::PH_COMMAND: begin
                w_size = C_SIZE;
                w_last = C_LAST;
            end
            default: begin
                w_size = M_SIZE;
                w_last = M_LAST;
            end
        endcase
    end

    assign w_lt_last = (r_pos < w_last);
    assign w_at_last = (r_pos == w_last);
    assign w_lt_size = (r_pos < w_size);
    assign w_cnt_inc = r_count + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_count   = r_count;
        n_swallow = 1'b0;
        w_wv      = 1'b0;
        w_kind    = clfs_pkg::KIND_METHOD;
        w_val     = '0;
        w_closed  = 1'b0;
        w_fin     = 1'b0;

        if (!(r_swallow && (w_cls == clfs_pkg::CLS_EOL))) begin
            case (r_phase)
                clfs_pkg::PH_METHOD: begin
                    w_kind = clfs_pkg::KIND_METHOD;
                    if (r_count == CNT_FULL) begin
                        w_fin = 1'b1;
                    end else begin
                        case (w_cls)
                            clfs_pkg::CLS_CH: begin
                                if (w_lt_last) begin
                                    w_wv  = 1'b1;
                                    w_val = w_byte;
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                            clfs_pkg::CLS_HASH: begin
                                if (r_pos == '0) begin
                                    n_phase = clfs_pkg::PH_COMMENT;
                                end
                            end
                            clfs_pkg::CLS_EOL: begin
                                n_swallow = 1'b1;
                                n_pos     = '0;
                            end
                            clfs_pkg::CLS_NUL: begin
                                w_fin = 1'b1;
                            end
                            clfs_pkg::CLS_COLON: begin
                                w_wv    = w_lt_size;
                                n_phase = clfs_pkg::PH_NAME;
                                n_pos   = '0;
                            end
                            default: begin
                                if (w_lt_last) begin
                                    w_wv  = 1'b1;
                                    w_val = w_byte;
                                    n_pos = r_pos + 1'b1;
                                end else if (w_at_last) begin
                                    w_wv  = 1'b1;
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                clfs_pkg::PH_NAME: begin
                    w_kind = clfs_pkg::KIND_NAME;
                    case (w_cls)
                        clfs_pkg::CLS_COLON: begin
                            w_wv    = w_lt_size;
                            n_phase = clfs_pkg::PH_COMMAND;
                            n_pos   = '0;
                        end
                        clfs_pkg::CLS_EOL: begin
                            w_wv      = w_lt_size;
                            n_swallow = 1'b1;
                            n_pos     = '0;
                            n_phase   = clfs_pkg::PH_METHOD;
                        end
                        clfs_pkg::CLS_NUL: begin
                            w_wv     = w_lt_size;
                            n_count  = w_cnt_inc;
                            w_closed = 1'b1;
                            w_fin    = 1'b1;
                        end
                        default: begin
                            if (w_lt_last) begin
                                w_wv  = 1'b1;
                                w_val = w_byte;
                                n_pos = r_pos + 1'b1;
                            end else if (w_at_last) begin
                                w_wv  = 1'b1;
                                n_pos = r_pos + 1'b1;
                            end
                        end
                    endcase
                end
                clfs_pkg::PH_COMMAND: begin
                    w_kind = clfs_pkg::KIND_COMMAND;
                    if ((w_cls == clfs_pkg::CLS_EOL) || (w_cls == clfs_pkg::CLS_NUL)) begin
                        w_wv      = w_lt_size;
                        n_count   = w_cnt_inc;
                        w_closed  = 1'b1;
                        n_pos     = '0;
                        n_phase   = clfs_pkg::PH_METHOD;
                        n_swallow = (w_cls == clfs_pkg::CLS_EOL);
                        w_fin     = (w_cls == clfs_pkg::CLS_NUL);
                    end else if (w_lt_last) begin
                        w_wv  = 1'b1;
                        w_val = w_byte;
                        n_pos = r_pos + 1'b1;
                    end else if (w_at_last) begin
                        w_wv  = 1'b1;
                        n_pos = r_pos + 1'b1;
                    end
                end
                default: begin
                    if (w_cls == clfs_pkg::CLS_EOL) begin
                        n_swallow = 1'b1;
                        n_phase   = clfs_pkg::PH_METHOD;
                        n_pos     = '0;
                    end else if (w_cls == clfs_pkg::CLS_NUL) begin
                        w_fin = 1'b1;
                    end
                end
            endcase
        end

        if (w_fin) begin
            n_phase   = clfs_pkg::PH_METHOD;
            n_pos     = '0;
            n_count   = '0;
            n_swallow = 1'b0;
        end
    end

    assign w_has = w_wv || w_closed || w_fin;

    always_comb begin
        w_res.write_valid  = w_wv;
        w_res.field_kind   = w_wv ? w_kind : clfs_pkg::KIND_METHOD;
        w_res.entry_index  = w_wv ? 8'(r_count) : 8'd0;
        w_res.char_pos     = w_wv ? 10'(r_pos) : 10'd0;
        w_res.char_value   = w_wv ? w_val : 8'd0;
        w_res.entry_closed = w_closed;
        w_res.finished     = w_fin;
        w_res.entry_count  = w_closed ? 9'(w_cnt_inc) : 9'(r_count);
    end

    assign i_item.ready     = !r_out_valid || o_result.ready;
    assign w_pop            = i_item.valid && i_item.ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= clfs_pkg::PH_METHOD;
            r_pos       <= '0;
            r_count     <= '0;
            r_swallow   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_count     <= n_count;
                r_swallow   <= n_swallow;
                r_out_valid <= w_has;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_has) begin
            r_out <= w_res;
        end
    end

endmodule

>>> verif/clfs_result_checker.sv
`timescale 1ns / 1ps

module clfs_result_checker import clfs_pkg::*; #(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int METHOD_BYTES  = METHOD_BYTES_DEF,
    parameter int NAME_BYTES    = NAME_BYTES_DEF,
    parameter int COMMAND_BYTES = COMMAND_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_text_valid,
    input  logic    i_text_ready,
    input  t_text   i_text,
    input  logic    i_result_valid,
    input  logic    i_result_ready,
    input  t_result i_result,
    output int      o_failures,
    output int      o_pending
);

    t_result     expected_writes[$];
    int          fail_count;

    t_phase      line_phase;
    int unsigned field_pos;
    int unsigned entries_done;
    bit          skip_eol;

    bit          wr_on;
    t_kind       wr_kind;
    int unsigned wr_index;
    int unsigned wr_pos;
    logic [7:0]  wr_char;

    task automatic rearm_parser();
        line_phase   = PH_METHOD;
        field_pos    = 0;
        entries_done = 0;
        skip_eol     = 1'b0;
    endtask

    task automatic note_write(input t_kind kind, input logic [7:0] value);
        wr_on    = 1'b1;
        wr_kind  = kind;
        wr_index = entries_done;
        wr_pos   = field_pos;
        wr_char  = value;
    endtask

    // The last slot of a field takes a terminator, and later bytes are dropped.
    task automatic store_char(input int unsigned size, input t_kind kind, input logic [7:0] b);
        if (field_pos + 1 < size) begin
            note_write(kind, b);
            field_pos++;
        end else if (field_pos + 1 == size) begin
            note_write(kind, CH_NUL);
            field_pos++;
        end
    endtask

    task automatic store_term(input int unsigned size, input t_kind kind);
        if (field_pos < size) begin
            note_write(kind, CH_NUL);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        bit      eol;
        bit      closed;
        bit      fin;
        t_result res;
        eol     = (b == CH_CR) || (b == CH_LF);
        closed  = 1'b0;
        fin     = 1'b0;
        wr_on   = 1'b0;
        wr_kind = KIND_METHOD;
        wr_index = 0;
        wr_pos  = 0;
        wr_char = CH_NUL;
        if (skip_eol) begin
            skip_eol = 1'b0;
            if (eol) begin
                return;
            end
        end
        case (line_phase)
            PH_METHOD: begin
                if (entries_done >= MAX_ENTRIES) begin
                    fin = 1'b1;
                end else if (b == CH_UPPER_C || b == CH_UPPER_H) begin
                    if (field_pos + 1 < METHOD_BYTES) begin
                        note_write(KIND_METHOD, b);
                        field_pos++;
                    end
                end else if (b == CH_HASH) begin
                    if (field_pos == 0) begin
                        line_phase = PH_COMMENT;
                    end
                end else if (eol) begin
                    skip_eol  = 1'b1;
                    field_pos = 0;
                end else if (b == CH_NUL) begin
                    fin = 1'b1;
                end else if (b == CH_COLON) begin
                    store_term(METHOD_BYTES, KIND_METHOD);
                    line_phase = PH_NAME;
                    field_pos  = 0;
                end else begin
                    store_char(METHOD_BYTES, KIND_METHOD, b);
                end
            end
            PH_NAME: begin
                if (b == CH_COLON) begin
                    store_term(NAME_BYTES, KIND_NAME);
                    line_phase = PH_COMMAND;
                    field_pos  = 0;
                end else if (eol) begin
                    skip_eol = 1'b1;
                    store_term(NAME_BYTES, KIND_NAME);
                    field_pos  = 0;
                    line_phase = PH_METHOD;
                end else if (b == CH_NUL) begin
                    store_term(NAME_BYTES, KIND_NAME);
                    entries_done++;
                    closed = 1'b1;
                    fin    = 1'b1;
                end else begin
                    store_char(NAME_BYTES, KIND_NAME, b);
                end
            end
            PH_COMMAND: begin
                if (eol || b == CH_NUL) begin
                    store_term(COMMAND_BYTES, KIND_COMMAND);
                    entries_done++;
                    closed     = 1'b1;
                    field_pos  = 0;
                    line_phase = PH_METHOD;
                    if (eol) begin
                        skip_eol = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    store_char(COMMAND_BYTES, KIND_COMMAND, b);
                end
            end
            default: begin
                if (eol) begin
                    skip_eol   = 1'b1;
                    line_phase = PH_METHOD;
                    field_pos  = 0;
                end else if (b == CH_NUL) begin
                    fin = 1'b1;
                end
            end
        endcase
        if (!(wr_on || closed || fin)) begin
            return;
        end
        res.write_valid  = wr_on;
        res.field_kind   = wr_kind;
        res.entry_index  = wr_index[7:0];
        res.char_pos     = wr_pos[9:0];
        res.char_value   = wr_char;
        res.entry_closed = closed;
        res.finished     = fin;
        res.entry_count  = entries_done[8:0];
        expected_writes.push_back(res);
        if (fin) begin
            rearm_parser();
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_writes.size() == 0) begin
            $error("Result beat arrived with no result expected.");
            fail_count++;
            return;
        end
        want = expected_writes.pop_front();
        compare_field("write_valid", want.write_valid, got.write_valid);
        compare_field("field_kind", want.field_kind, got.field_kind);
        compare_field("entry_index", want.entry_index, got.entry_index);
        compare_field("char_pos", want.char_pos, got.char_pos);
        compare_field("char_value", want.char_value, got.char_value);
        compare_field("entry_closed", want.entry_closed, got.entry_closed);
        compare_field("finished", want.finished, got.finished);
        compare_field("entry_count", want.entry_count, got.entry_count);
    endtask

    initial begin
        fail_count = 0;
        rearm_parser();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rearm_parser();
            expected_writes.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                check_result(i_result);
            end
            if (i_text_valid && i_text_ready) begin
                predict_byte(i_text.text_byte);
            end
        end
        o_failures <= fail_count;
        o_pending  <= expected_writes.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import clfs_pkg::*;

    localparam int MAX_ENTRIES   = MAX_ENTRIES_DEF;
    localparam int METHOD_BYTES  = METHOD_BYTES_DEF;
    localparam int NAME_BYTES    = NAME_BYTES_DEF;
    localparam int COMMAND_BYTES = COMMAND_BYTES_DEF;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    int         failures;
    int         pending;
    logic [7:0] text_bytes[$];

    clfs_stream_if #(.t_payload(t_text))   text_ch ();
    clfs_stream_if #(.t_payload(t_result)) result_ch ();

    command_file_line_splitter #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .METHOD_BYTES (METHOD_BYTES),
        .NAME_BYTES   (NAME_BYTES),
        .COMMAND_BYTES(COMMAND_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_result(result_ch)
    );

    clfs_result_checker #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .METHOD_BYTES (METHOD_BYTES),
        .NAME_BYTES   (NAME_BYTES),
        .COMMAND_BYTES(COMMAND_BYTES)
    ) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_valid  (text_ch.valid),
        .i_text_ready  (text_ch.ready),
        .i_text        (text_ch.payload),
        .i_result_valid(result_ch.valid),
        .i_result_ready(result_ch.ready),
        .i_result      (result_ch.payload),
        .o_failures    (failures),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] plain_byte(input bit allow_colon);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == CH_CR || b == CH_LF || (!allow_colon && b == CH_COLON));
        return b;
    endfunction

    task automatic push_field(input t_kind kind, input int len);
        int i;
        for (i = 0; i < len; i++) begin
            if (kind == KIND_METHOD && $urandom_range(0, 9) < 3) begin
                text_bytes.push_back($urandom_range(0, 1) ? CH_UPPER_C : CH_UPPER_H);
            end else if (kind == KIND_COMMAND && $urandom_range(0, 9) == 0) begin
                text_bytes.push_back(CH_COLON);
            end else begin
                text_bytes.push_back(plain_byte(kind == KIND_COMMAND));
            end
        end
    endtask

    task automatic push_line_end();
        case ($urandom_range(0, 5))
            0: text_bytes.push_back(CH_CR);
            1: text_bytes.push_back(CH_LF);
            2: begin
                text_bytes.push_back(CH_CR);
                text_bytes.push_back(CH_LF);
            end
            3: begin
                text_bytes.push_back(CH_LF);
                text_bytes.push_back(CH_CR);
            end
            4: repeat (3) text_bytes.push_back(CH_LF);
            default: repeat (2) text_bytes.push_back(CH_CR);
        endcase
    endtask

    task automatic push_line();
        int shape;
        shape = $urandom_range(0, 99);
        if (shape < 65) begin
            push_field(KIND_METHOD, ($urandom_range(0, 3) == 0) ? $urandom_range(6, 10)
                                                                 : $urandom_range(0, 5));
            text_bytes.push_back(CH_COLON);
            push_field(KIND_NAME, ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                               : $urandom_range(0, 8));
            text_bytes.push_back(CH_COLON);
            push_field(KIND_COMMAND, $urandom_range(0, 12));
        end else if (shape < 75) begin
            text_bytes.push_back(CH_HASH);
            push_field(KIND_COMMAND, $urandom_range(0, 10));
        end else if (shape < 85) begin
            push_field(KIND_METHOD, $urandom_range(0, 9));
            if ($urandom_range(0, 1)) begin
                text_bytes.push_back(CH_COLON);
                push_field(KIND_NAME, $urandom_range(0, 8));
            end
        end else begin
            repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom_range(1, 255)));
        end
        push_line_end();
    endtask

    // A buffer ends with a NUL that lands in a random field or in a comment line.
    task automatic push_buffer();
        repeat ($urandom_range(1, 12)) push_line();
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                push_field(KIND_METHOD, $urandom_range(0, 4));
                text_bytes.push_back(CH_COLON);
                push_field(KIND_NAME, $urandom_range(0, 5));
            end
            2: begin
                push_field(KIND_METHOD, $urandom_range(0, 4));
                text_bytes.push_back(CH_COLON);
                push_field(KIND_NAME, $urandom_range(0, 5));
                text_bytes.push_back(CH_COLON);
                push_field(KIND_COMMAND, $urandom_range(0, 5));
            end
            3: begin
                text_bytes.push_back(CH_HASH);
                push_field(KIND_COMMAND, $urandom_range(0, 4));
            end
            default: push_field(KIND_METHOD, $urandom_range(0, 4));
        endcase
        text_bytes.push_back(CH_NUL);
    endtask

    task automatic build_directed();
        text_bytes.push_back(CH_HASH);
        text_bytes.push_back("c");
        text_bytes.push_back(CH_CR);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back("a");
        text_bytes.push_back(CH_HASH);
        text_bytes.push_back(CH_UPPER_C);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back("n");
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_UPPER_H);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back("y");
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back("z");
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back(CH_CR);
        text_bytes.push_back(8'hFF);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back(8'h01);
        text_bytes.push_back(CH_NUL);
        text_bytes.push_back(CH_HASH);
        text_bytes.push_back(CH_NUL);
        text_bytes.push_back(CH_NUL);
        text_bytes.push_back(8'h7F);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back(8'h80);
        text_bytes.push_back(CH_NUL);
    endtask

    // Fills every entry of the table, then a further byte finishes the parse.
    task automatic build_full_table();
        repeat (MAX_ENTRIES) begin
            text_bytes.push_back(CH_COLON);
            text_bytes.push_back(CH_COLON);
            push_field(KIND_COMMAND, $urandom_range(0, 1));
            text_bytes.push_back(CH_LF);
        end
        if ($urandom_range(0, 1)) begin
            text_bytes.push_back(CH_CR);
        end
        text_bytes.push_back(plain_byte(1'b1));
    endtask

    task automatic build_long_fields();
        text_bytes.push_back(CH_UPPER_H);
        text_bytes.push_back(CH_COLON);
        push_field(KIND_NAME, NAME_BYTES + 6);
        text_bytes.push_back(CH_COLON);
        push_field(KIND_COMMAND, COMMAND_BYTES + 6);
        text_bytes.push_back(CH_LF);
        text_bytes.push_back(CH_NUL);
    endtask

    initial begin
        t_rx_mode mode;
        int       span;
        int       k;
        int       phases;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        phases = 0;
        forever begin
            phases++;
            // One long hold-off so that the block fills up and stalls its input.
            if (phases == 4) begin
                result_ch.ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            for (k = 0; k < span; k++) begin
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ch.ready <= (k % 3 != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int burst_left;
        int gap;
        int idx;
        int start;
        int wait_cycles;
        text_ch.valid   <= 1'b0;
        text_ch.payload <= '0;
        i_rst_n         <= 1'b0;
        build_directed();
        build_full_table();
        build_long_fields();
        start = text_bytes.size();
        while (text_bytes.size() - start < 1500) push_buffer();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = 0;
        for (idx = 0; idx < text_bytes.size(); idx++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 30);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    text_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            text_ch.valid   <= 1'b1;
            text_ch.payload <= text_bytes[idx];
            do @(posedge i_clk); while (!text_ch.ready);
        end
        text_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (pending != 0) begin
            $error("%0d expected results never arrived.", pending);
        end
        if (failures == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
